// ===== rtl/gha_pkg.sv =====
package gha_pkg;

	localparam int SLOT_COUNT_DEF = 1024;
	localparam int GEN_BITS_DEF   = 16;

	localparam int REQ_W  = 2;
	localparam int IDX_W  = 10;
	localparam int GEN_W  = 16;
	localparam int STAT_W = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_CREATE   = 2'd0,
		REQ_DESTROY  = 2'd1,
		REQ_VALIDATE = 2'd2
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_STALE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_DONE
	} state_t;

endpackage

// ===== rtl/gha_if.sv =====
interface gha_req_if
	import gha_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [IDX_W-1:0] slot_index;
	logic [GEN_W-1:0] slot_generation;

	modport source (output valid, req_type, slot_index, slot_generation, input ready);
	modport sink (input valid, req_type, slot_index, slot_generation, output ready);
endinterface

interface gha_rsp_if
	import gha_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [IDX_W-1:0]  handle_index;
	logic [GEN_W-1:0]  handle_generation;
	logic              handle_valid;

	modport source (output valid, status, handle_index, handle_generation, handle_valid,
		input ready);
	modport sink (input valid, status, handle_index, handle_generation, handle_valid,
		output ready);
endinterface

// ===== rtl/generational_handle_allocator_top.sv =====
// The result register loads in S_DONE, which directly follows the accepted transaction for
// destroy, validate and a fresh-index create, and follows S_POP for a create that pops the
// stack; S_DONE waits for any earlier response to be taken. A new request is accepted only in
// S_IDLE, after the previous result has loaded. Reset clears the FSM, the counters and the
// response valid flag at once; the memories need no clearing because only entries below the
// free count or the high-water mark are ever used.
module generational_handle_allocator_top
	import gha_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int GEN_BITS   = GEN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	gha_req_if.sink     req,
	gha_rsp_if.source   rsp
);

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = IW + 1;
	localparam int XW = (IW > IDX_W) ? IW : IDX_W;
	localparam int GW = (GEN_BITS > GEN_W) ? GEN_BITS : GEN_W;

	// Generation table and free stack.
	logic [GEN_BITS-1:0] gen_mem [SLOT_COUNT];
	logic [IW-1:0]       stk_mem [SLOT_COUNT];

	state_t state_q, state_d;

	logic [REQ_W-1:0] req_type_q;
	logic [IDX_W-1:0] idx_q;
	logic [GEN_W-1:0] gen_q;

	logic [CW-1:0] free_count_q, free_count_d;
	logic [CW-1:0] mark_q, mark_d;

	logic                gen_rd_en;
	logic [IW-1:0]       gen_rd_addr;
	logic [GEN_BITS-1:0] gen_rd_q;
	logic                stk_rd_en;
	logic [IW-1:0]       stk_rd_q;
	logic [CW-1:0]       fc_m1;

	logic                gen_wr_en;
	logic [IW-1:0]       gen_wr_addr;
	logic [GEN_BITS-1:0] gen_wr_data;
	logic                stk_wr_en;

	logic                req_ready;
	logic                accept;
	logic                fire;

	logic                rsp_valid_q;
	status_t             status_q, res_status;
	logic [IDX_W-1:0]    hidx_q, res_idx;
	logic [GEN_W-1:0]    hgen_q;
	logic [GW-1:0]       res_gen;
	logic                hvalid_q, res_valid;

	logic [XW-1:0]       in_idx_x;
	logic [XW-1:0]       idx_x;
	logic [GW-1:0]       gin_x;
	logic                in_range;
	logic                handle_ok;
	logic [GEN_BITS-1:0] gen_inc;
	logic [IW-1:0]       slot_addr;

	assign accept    = req.valid && req_ready;
	assign req.ready = req_ready;
	assign fire      = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);
	assign fc_m1     = free_count_q - CW'(1);
	assign in_idx_x  = XW'(req.slot_index);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.req_type == REQ_CREATE && free_count_q != '0)
						state_d = S_POP;
					else
						state_d = S_DONE;
				end
			end
			S_POP:   state_d = S_DONE;
			S_DONE: begin
				if (fire)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// FSM outputs: handshake and memory read issue.
	always_comb begin
		req_ready   = 1'b0;
		gen_rd_en   = 1'b0;
		gen_rd_addr = in_idx_x[IW-1:0];
		stk_rd_en   = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				gen_rd_en = accept;
				stk_rd_en = accept;
			end
			S_POP: begin
				gen_rd_en   = 1'b1;
				gen_rd_addr = stk_rd_q;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	// Result and state update, applied when the result register is loaded.
	always_comb begin
		idx_x     = XW'(idx_q);
		gin_x     = GW'(gen_q);
		in_range  = {1'b0, idx_x} < (XW + 1)'(mark_q);
		slot_addr = idx_x[IW-1:0];
		handle_ok = in_range && (gen_rd_q == gin_x[GEN_BITS-1:0]);
		gen_inc   = gen_rd_q + GEN_BITS'(1);

		res_status   = ST_STALE;
		res_idx      = idx_q;
		res_gen      = '0;
		res_valid    = 1'b0;
		free_count_d = free_count_q;
		mark_d       = mark_q;
		gen_wr_en    = 1'b0;
		gen_wr_addr  = slot_addr;
		gen_wr_data  = gen_inc;
		stk_wr_en    = 1'b0;

		case (req_type_q)
			REQ_CREATE: begin
				if (free_count_q != '0) begin
					res_status   = ST_OK;
					res_idx      = IDX_W'(XW'(stk_rd_q));
					res_gen      = GW'(gen_rd_q);
					free_count_d = fc_m1;
				end else if (mark_q < CW'(SLOT_COUNT)) begin
					// A fresh slot starts at generation zero; writing it here keeps every
					// table entry below the mark defined.
					res_status  = ST_OK;
					res_idx     = IDX_W'(XW'(mark_q[IW-1:0]));
					gen_wr_en   = 1'b1;
					gen_wr_addr = mark_q[IW-1:0];
					gen_wr_data = '0;
					mark_d      = mark_q + CW'(1);
				end else begin
					res_status = ST_FULL;
					res_idx    = '0;
				end
			end
			REQ_DESTROY: begin
				if (handle_ok) begin
					res_status = ST_OK;
					res_valid  = 1'b1;
					res_gen    = GW'(gen_inc);
					gen_wr_en  = 1'b1;
					if (free_count_q < CW'(SLOT_COUNT)) begin
						stk_wr_en    = 1'b1;
						free_count_d = free_count_q + CW'(1);
					end
				end else if (in_range) begin
					res_gen = GW'(gen_rd_q);
				end
			end
			REQ_VALIDATE: begin
				if (handle_ok) begin
					res_status = ST_OK;
					res_valid  = 1'b1;
				end
				if (in_range)
					res_gen = GW'(gen_rd_q);
			end
			default: begin
				res_status = ST_STALE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			free_count_q <= '0;
			mark_q       <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				free_count_q <= free_count_d;
				mark_q       <= mark_d;
				rsp_valid_q  <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req.req_type;
			idx_q      <= req.slot_index;
			gen_q      <= req.slot_generation;
		end
		if (fire) begin
			status_q <= res_status;
			hidx_q   <= res_idx;
			hgen_q   <= res_gen[GEN_W-1:0];
			hvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_rd_en)
			gen_rd_q <= gen_mem[gen_rd_addr];
		if (fire && gen_wr_en)
			gen_mem[gen_wr_addr] <= gen_wr_data;
	end

	always_ff @(posedge clk) begin
		if (stk_rd_en)
			stk_rd_q <= stk_mem[fc_m1[IW-1:0]];
		if (fire && stk_wr_en)
			stk_mem[free_count_q[IW-1:0]] <= slot_addr;
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.status            = status_q;
	assign rsp.handle_index      = hidx_q;
	assign rsp.handle_generation = hgen_q;
	assign rsp.handle_valid      = hvalid_q;

`ifndef NO_ASSERTIONS
	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= CW'(SLOT_COUNT) && mark_q <= CW'(SLOT_COUNT))
		else $error("free count or high-water mark beyond capacity");

	a_mark_steps: assert property (@(posedge clk) disable iff (!arst_n)
		mark_q != $past(mark_q) |-> mark_q == $past(mark_q) + CW'(1))
		else $error("high-water mark moved by other than one");

	a_pop_only_create: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP |-> req_type_q == REQ_CREATE && free_count_q != '0)
		else $error("stack pop without a create on a nonempty stack");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted transaction left no work in flight");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q == ST_FULL |-> free_count_q == '0 &&
		mark_q == CW'(SLOT_COUNT))
		else $error("no-free-slot result while a slot was available");
`endif

endmodule
